FILE: hdl/pud_pkg.sv
// ----------------------------------------------------------------------------
// pud_pkg: shared types and constants of the percent URL decoder
// Holds the group record that travels from the front through the queue to
// the back, the escape character and the hex digit helpers.
// ----------------------------------------------------------------------------
package pud_pkg;

  // Escape character that opens a percent sequence.
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Most decoded bytes that one input item can cause.
  localparam int unsigned MAX_RESULTS = 3;

  // Decoded bytes caused by one input item, in order of emission.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]                  cnt;     // number of valid bytes, 1 to 3
    logic                        str_end; // last byte closes the string
  } pud_group_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Value of a hex digit; meaningless for other characters.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

FILE: hdl/pud_front.sv
// ----------------------------------------------------------------------------
// pud_front: input classifier of the percent URL decoder
// Accepts one character per cycle while the queue has room, tracks a
// pending escape and makes each item a group of zero to three queued bytes.
// ----------------------------------------------------------------------------
module pud_front
  import pud_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_end_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output pud_group_t group_o
);

  // Pending escape codes.
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  logic [1:0] pend_q, pend_d;
  logic [7:0] first_q, first_d;
  logic       accept;
  logic [1:0] n;
  logic [MAX_RESULTS-1:0][7:0] bytes;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the character against the pending escape and collect bytes.
  always_comb begin
    n       = 2'd0;
    bytes   = '0;
    pend_d  = PEND_NONE;
    first_d = first_q;
    unique case (pend_q)
      PEND_PCT: begin
        if (is_hex(in_byte_i)) begin
          pend_d  = PEND_DIGIT;
          first_d = in_byte_i;
        end else begin
          bytes[n] = PCT_CHAR;
          n = n + 2'd1;
          if (in_byte_i == PCT_CHAR) begin
            pend_d = PEND_PCT;
          end else begin
            bytes[n] = in_byte_i;
            n = n + 2'd1;
          end
        end
      end
      PEND_DIGIT: begin
        if (is_hex(in_byte_i)) begin
          bytes[n] = {hex_nibble(first_q), hex_nibble(in_byte_i)};
          n = n + 2'd1;
        end else begin
          bytes[n] = PCT_CHAR;
          n = n + 2'd1;
          bytes[n] = first_q;
          n = n + 2'd1;
          if (in_byte_i == PCT_CHAR) begin
            pend_d = PEND_PCT;
          end else begin
            bytes[n] = in_byte_i;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        if (in_byte_i == PCT_CHAR) begin
          pend_d = PEND_PCT;
        end else begin
          bytes[n] = in_byte_i;
          n = n + 2'd1;
        end
      end
    endcase
    // At the end of the string flush whatever is still held.
    if (string_end_i) begin
      if (pend_d != PEND_NONE) begin
        bytes[n] = PCT_CHAR;
        n = n + 2'd1;
      end
      if (pend_d == PEND_DIGIT) begin
        bytes[n] = first_d;
        n = n + 2'd1;
      end
      pend_d = PEND_NONE;
    end
  end

  assign push_o          = accept && (n != 2'd0);
  assign group_o.bytes   = bytes;
  assign group_o.cnt     = n;
  assign group_o.str_end = string_end_i;

  // Escape state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PEND_NONE;
      first_q <= 8'h00;
    end else if (accept) begin
      pend_q  <= pend_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: hdl/pud_queue.sv
// ----------------------------------------------------------------------------
// pud_queue: group queue of the percent URL decoder
// A small register FIFO of byte groups that decouples the classifier from
// the output serializer.
// ----------------------------------------------------------------------------
module pud_queue
  import pud_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pud_group_t group_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output pud_group_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pud_group_t             mem_q [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the fill count guards it.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= group_i;
    end
  end

endmodule

FILE: hdl/pud_back.sv
// ----------------------------------------------------------------------------
// pud_back: output serializer of the percent URL decoder
// Sends the bytes of the group at the queue head one per cycle while the
// receiver is ready, and marks the last byte of each group and of each string.
// ----------------------------------------------------------------------------
module pud_back
  import pud_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  pud_group_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       decoded_end_o,
  output logic       run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       last_in_group;
  logic       accept;

  assign last_in_group = (idx_q == (head_i.cnt - 2'd1));
  assign accept        = out_valid_o && out_ready_i;

  assign out_valid_o   = head_valid_i;
  assign out_byte_o    = head_i.bytes[idx_q];
  assign run_last_o    = last_in_group;
  assign decoded_end_o = last_in_group && head_i.str_end;
  assign pop_o         = accept && last_in_group;

  // Step through the group; restart at the first byte of the next one.
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = last_in_group ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: hdl/percent_url_decoder_unit.sv
// ----------------------------------------------------------------------------
// percent_url_decoder_unit: streaming URL percent decoder
// Decodes %XX escapes in a character stream, one input byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis: tdata carries one encoded character, tlast marks
//   the final character of a string. Master stream m_axis: tdata carries
//   one decoded byte, tlast marks the final decoded byte of a string and
//   tuser marks the last byte caused by one input item.
//   A character that only extends a pending escape causes no output; an
//   invalid escape is passed through unchanged, and a pending '%' or '%X'
//   is flushed at the end of the string.
// Throughput:
//   Input is taken every cycle while the group queue has room. The output
//   serializer sends one byte per cycle while the receiver is ready, so an
//   item that causes two or three bytes holds the queue head until all of
//   them are sent; the queue depth (QUEUE_DEPTH groups) sets how long the
//   input keeps flowing then.
// Reset and stall:
//   Reset clears the escape state and empties the queue. When the receiver
//   stalls, output bytes hold and the input keeps flowing until the queue
//   fills, after which s_axis_tready goes low.
// ----------------------------------------------------------------------------
module percent_url_decoder_unit
  import pud_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // string_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // decoded_end
  output logic       m_axis_tuser_o    // [0] run_last
);

  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  pud_group_t group;
  pud_group_t head;

  // Classifier and escape state.
  pud_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .string_end_i (s_axis_tlast_i),
    .queue_full_i (full),
    .push_o       (push),
    .group_o      (group)
  );

  // Group queue between the two halves.
  pud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .group_i (group),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // Byte serializer.
  pud_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .decoded_end_o (m_axis_tlast_o),
    .run_last_o    (m_axis_tuser_o)
  );

endmodule

FILE: hdl/pud_checker.sv
// ----------------------------------------------------------------------------
// pud_checker: port-level checks of the percent URL decoder
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  // A stalled output item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item withdrawn while stalled");

  // A stalled output item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("output item changed while stalled");

  // The end of a decoded string is always the last byte of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("decoded end on a byte that is not last of its item");

  // Nothing is offered while reset is held.
  assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A last character other than '%', taken while no output is offered, yields output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i &&
    (s_axis_tdata_i != 8'h25) |=> m_axis_tvalid_o)
    else $error("string end produced no output");

endmodule

bind percent_url_decoder_unit pud_checker u_pud_checker (.*);

FILE: tb/pud_checker.sv
// ----------------------------------------------------------------------------
// pud_scoreboard: scoreboard for the percent URL decoder
// Watches both stream channels. Each accepted input item is decoded by a
// local model of the escape logic, and the decoded bytes are queued. Each
// accepted output item is compared field by field with the oldest queued
// byte.
// ----------------------------------------------------------------------------
module pud_scoreboard
  import pud_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,
  input  logic       m_tlast_i,
  input  logic       m_tuser_i,
  output int         err_cnt_o,
  output int         open_o,
  output int         checked_o,
  output int         escapes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEX_BASE = 16;

  // Escape progress: nothing held, a '%' held, or '%' and one digit held.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_state_e;

  // One decoded byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       str_end;
    logic       run_last;
  } dec_byte_t;

  esc_state_e esc_q      = ESC_NONE;
  logic [7:0] held_digit = '0;
  dec_byte_t  decoded_q[$];
  int         err_cnt    = 0;
  int         checked    = 0;
  int         escapes    = 0;

  // Digit value of a hex character, or -1 for anything else.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // Advance the escape state by one character and queue what it yields.
  task automatic decode_item(input logic [7:0] c, input logic last);
    logic [7:0] bytes_q[$];
    esc_state_e held;
    logic       reexamine;
    dec_byte_t  e;
    held      = esc_q;
    esc_q     = ESC_NONE;
    reexamine = 1'b0;
    case (held)
      ESC_PCT: begin
        if (hex_val(c) >= 0) begin
          esc_q      = ESC_DIGIT;
          held_digit = c;
        end else begin
          bytes_q.push_back(PCT_CHAR);
          reexamine = 1'b1;
        end
      end
      ESC_DIGIT: begin
        if (hex_val(held_digit) >= 0 && hex_val(c) >= 0) begin
          bytes_q.push_back(8'(hex_val(held_digit) * HEX_BASE + hex_val(c)));
          escapes++;
        end else begin
          // Broken escape: pass the '%' and the digit, then look at c afresh.
          bytes_q.push_back(PCT_CHAR);
          bytes_q.push_back(held_digit);
          reexamine = 1'b1;
        end
      end
      default: begin
        reexamine = 1'b1;
      end
    endcase
    if (reexamine) begin
      if (c == PCT_CHAR) begin
        esc_q = ESC_PCT;
      end else begin
        bytes_q.push_back(c);
      end
    end
    // The end of a string flushes whatever is still held.
    if (last) begin
      if (esc_q != ESC_NONE) bytes_q.push_back(PCT_CHAR);
      if (esc_q == ESC_DIGIT) bytes_q.push_back(held_digit);
      esc_q = ESC_NONE;
    end
    foreach (bytes_q[i]) begin
      e.data     = bytes_q[i];
      e.run_last = (i == bytes_q.size() - 1);
      e.str_end  = last && e.run_last;
      decoded_q.push_back(e);
    end
  endtask

  // Compare output items first; input items only add later expectations.
  always @(posedge clk_i) begin
    dec_byte_t want;
    if (!rst_ni) begin
      esc_q      = ESC_NONE;
      held_digit = '0;
      decoded_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected output item: expected none, got data %h last %b user %b",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          want = decoded_q.pop_front();
          checked++;
          if (m_tdata_i !== want.data) begin
            err_cnt++;
            $display("%0t: out_byte mismatch: expected %h, got %h",
                     $time, want.data, m_tdata_i);
          end
          if (m_tlast_i !== want.str_end) begin
            err_cnt++;
            $display("%0t: decoded_end mismatch: expected %b, got %b",
                     $time, want.str_end, m_tlast_i);
          end
          if (m_tuser_i !== want.run_last) begin
            err_cnt++;
            $display("%0t: run_last mismatch: expected %b, got %b",
                     $time, want.run_last, m_tuser_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        decode_item(s_tdata_i, s_tlast_i);
      end
    end
    err_cnt_o <= err_cnt;
    open_o    <= decoded_q.size();
    checked_o <= checked;
    escapes_o <= escapes;
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for percent_url_decoder_unit
// Sends a short directed set of strings covering valid, broken and
// unterminated escapes, then random strings built mostly from well-formed
// escapes. Both stream sides idle at random, and once the receiver holds
// off long enough to back up the input. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb
  import pud_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 450;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int TAIL_CYCLES = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_valid = 1'b0;
  logic       s_ready;
  logic [7:0] s_data = '0;
  logic       s_last = 1'b0;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;
  logic       m_last;
  logic       m_user;

  int err_cnt;
  int open_cnt;
  int checked;
  int escapes;

  int items_sent  = 0;
  int strings     = 0;
  int idle_cycles = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;
  logic [7:0] run_q[$];

  percent_url_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  pud_scoreboard u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_ready),
    .s_tdata_i  (s_data),
    .s_tlast_i  (s_last),
    .m_tvalid_i (m_valid),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_data),
    .m_tlast_i  (m_last),
    .m_tuser_i  (m_user),
    .err_cnt_o  (err_cnt),
    .open_o     (open_cnt),
    .checked_o  (checked),
    .escapes_o  (escapes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("percent_url_decoder_unit regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random hold-off before each output item, or a long one on request.
  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        gap         = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  // Offer one character after a random gap and wait until it is taken.
  task automatic send_item(input logic [7:0] c, input logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    items_sent++;
  endtask

  // Send the characters in run_q as one string.
  task automatic send_run();
    foreach (run_q[i]) begin
      send_item(run_q[i], i == run_q.size() - 1);
    end
    strings++;
  endtask

  task automatic send_text(input string s);
    run_q.delete();
    for (int i = 0; i < s.len(); i++) run_q.push_back(s[i]);
    send_run();
  endtask

  // A hex digit character of either case.
  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  // Any character, with the out-of-range zero byte now and then.
  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 63) == 0) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  // Append one piece of a string: mostly well-formed escapes, some noise.
  task automatic add_token();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      run_q.push_back(PCT_CHAR);
      run_q.push_back(rand_hex());
      run_q.push_back(rand_hex());
    end else if (pick < 15) begin
      run_q.push_back(rand_char());
    end else if (pick < 17) begin
      run_q.push_back(PCT_CHAR);
      run_q.push_back(rand_hex());
      run_q.push_back(rand_char());
    end else if (pick < 19) begin
      run_q.push_back(PCT_CHAR);
      run_q.push_back(rand_char());
    end else begin
      run_q.push_back(PCT_CHAR);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes and the zero byte, then the escape cases.
    run_q = '{8'h00, 8'hFF, 8'h01};
    send_run();
    send_text("%41%aF%00");
    // Bad first digit, '%' after '%', bad second digit, three-byte burst.
    send_text("%G%%4%4f%4z");
    // Strings that end on a pending '%' and on a pending '%X'.
    send_text("%");
    send_text("%7");

    // Random strings, with one long receiver stall partway through.
    while (items_sent < ITEM_TARGET) begin
      run_q.delete();
      repeat ($urandom_range(1, 5)) add_token();
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      send_run();
      if (strings == 40) begin
        tx_quiet    = 1'b1;
        rx_hold_req = 1'b1;
        run_q.delete();
        repeat (24) run_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        send_run();
      end
    end
    s_valid <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Let the checker count the last item, drain, then allow a few more cycles.
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings; checked %0d decoded bytes, %0d escapes.",
             items_sent, strings, checked, escapes);
    $display("Random gaps on both sides plus one long output stall that backed up the input.");
    if (err_cnt == 0) begin
      $display("percent_url_decoder_unit regression: pass");
    end else begin
      $display("percent_url_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
